[sv/lca_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and arithmetic helpers for the 3D line closest-approach block.
// No dependencies; every other file in sv/ uses this package.
package lca_pkg;

    localparam int FRAC_BITS_DEF = 16;
    // Quotient bits produced by the divider: 31 magnitude bits plus two guard bits.
    localparam int QBITS         = 33;
    localparam int ROOT_BITS     = 32;

    typedef logic [2:0][31:0] t_vec3;

    typedef struct packed {
        logic signed [31:0] first_origin_x;
        logic signed [31:0] first_origin_y;
        logic signed [31:0] first_origin_z;
        logic signed [31:0] first_dir_x;
        logic signed [31:0] first_dir_y;
        logic signed [31:0] first_dir_z;
        logic signed [31:0] second_origin_x;
        logic signed [31:0] second_origin_y;
        logic signed [31:0] second_origin_z;
        logic signed [31:0] second_dir_x;
        logic signed [31:0] second_dir_y;
        logic signed [31:0] second_dir_z;
    } t_lca_in;

    typedef struct packed {
        logic               not_parallel;
        logic signed [31:0] first_param;
        logic signed [31:0] second_param;
        logic [31:0]        line_distance;
        logic               lines_meet;
        logic               overflow;
    } t_lca_out;

    typedef struct packed {
        logic  par;
        logic  ovf;
        t_vec3 p1;
        t_vec3 d1;
        t_vec3 p2;
        t_vec3 d2;
    } t_side;

    typedef struct packed {
        t_side       side;
        logic [63:0] k;
        logic [63:0] dvd1;
        logic [63:0] dvd2;
        logic        neg1;
        logic        neg2;
    } t_div_in;

    typedef struct packed {
        t_side              side;
        logic signed [31:0] t1;
        logic signed [31:0] t2;
    } t_div_out;

    typedef struct packed {
        logic               par;
        logic               ovf;
        logic               meet;
        logic signed [31:0] t1;
        logic signed [31:0] t2;
    } t_tail;

    typedef struct packed {
        t_tail       tail;
        logic [63:0] x;
    } t_root_in;

    typedef struct packed {
        t_tail                 tail;
        logic [ROOT_BITS-1:0]  root;
    } t_root_out;

    // Fixed-point product, floor of a*b / 2^f.
    function automatic logic signed [63:0] fmul(input logic signed [31:0] a,
                                                input logic signed [31:0] b,
                                                input int f);
        logic signed [63:0] p;
        p = a * b;
        return p >>> f;
    endfunction

    // Clamp to 32-bit signed; bit 32 of the result flags a clamp.
    function automatic logic [32:0] sat32(input logic signed [65:0] x);
        if (x > 66'sd2147483647) begin
            return {1'b1, 32'h7FFF_FFFF};
        end else if (x < -66'sd2147483648) begin
            return {1'b1, 32'h8000_0000};
        end else begin
            return {1'b0, x[31:0]};
        end
    endfunction

endpackage

[sv/lca_geom.sv]
`timescale 1ns / 1ps
// Front pipeline: cross products, |c|^2, numerators, parallel test, divider operands.
// Depends on lca_pkg.
module lca_geom #(
    parameter int FRAC_BITS = lca_pkg::FRAC_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  lca_pkg::t_lca_in i_data,
    input  logic [31:0]      i_eps,
    output logic             o_valid,
    output lca_pkg::t_div_in o_data
);

    lca_pkg::t_vec3 w_p1, w_d1, w_p2, w_d2;
    assign w_p1 = {i_data.first_origin_z, i_data.first_origin_y, i_data.first_origin_x};
    assign w_d1 = {i_data.first_dir_z, i_data.first_dir_y, i_data.first_dir_x};
    assign w_p2 = {i_data.second_origin_z, i_data.second_origin_y, i_data.second_origin_x};
    assign w_d2 = {i_data.second_dir_z, i_data.second_dir_y, i_data.second_dir_x};

    // stage 1: d1 x d2 partial products, P = p2 - p1
    logic [2:0]         w1_f;
    logic signed [63:0] n1_cm [6];
    logic signed [31:0] n1_pd [3];
    lca_pkg::t_side     n1_side;
    logic signed [63:0] r1_cm [6];
    logic signed [31:0] r1_pd [3];
    lca_pkg::t_side     r1_side;
    logic               r1_vld;

    // stage 2: c, partial products of P x d2 and P x d1
    logic [2:0]         w2_f;
    logic signed [31:0] n2_c  [3];
    logic signed [63:0] n2_um [6];
    logic signed [63:0] n2_vm [6];
    lca_pkg::t_side     n2_side;
    logic signed [31:0] r2_c  [3];
    logic signed [63:0] r2_um [6];
    logic signed [63:0] r2_vm [6];
    lca_pkg::t_side     r2_side;
    logic               r2_vld;

    // stage 3: u, v, c squared terms
    logic [5:0]         w3_f;
    logic signed [31:0] n3_u  [3];
    logic signed [31:0] n3_v  [3];
    logic signed [63:0] n3_cc [3];
    lca_pkg::t_side     n3_side;
    logic signed [31:0] r3_u  [3];
    logic signed [31:0] r3_v  [3];
    logic signed [31:0] r3_c  [3];
    logic signed [63:0] r3_cc [3];
    lca_pkg::t_side     r3_side;
    logic               r3_vld;

    // stage 4: k, dot-product terms
    logic signed [63:0] n4_uc [3];
    logic signed [63:0] n4_vc [3];
    logic signed [63:0] r4_uc [3];
    logic signed [63:0] r4_vc [3];
    logic [63:0]        r4_k;
    lca_pkg::t_side     r4_side;
    logic               r4_vld;

    // stage 5: numerators, parallel flag
    lca_pkg::t_side     n5_side;
    logic signed [63:0] r5_n1, r5_n2;
    logic [63:0]        r5_k;
    lca_pkg::t_side     r5_side;
    logic               r5_vld;

    // stage 6: divider operands
    lca_pkg::t_div_in   n6_data;
    lca_pkg::t_div_in   r6_data;
    logic               r6_vld;

    for (genvar g = 0; g < 3; g++) begin : g_s1
        localparam int J = (g + 1) % 3;
        localparam int M = (g + 2) % 3;
        logic [32:0] w_pd;
        assign n1_cm[2*g]   = lca_pkg::fmul($signed(w_d1[J]), $signed(w_d2[M]), FRAC_BITS);
        assign n1_cm[2*g+1] = lca_pkg::fmul($signed(w_d1[M]), $signed(w_d2[J]), FRAC_BITS);
        assign w_pd     = lca_pkg::sat32(66'($signed(w_p2[g])) - 66'($signed(w_p1[g])));
        assign n1_pd[g] = w_pd[31:0];
        assign w1_f[g]  = w_pd[32];
    end

    always_comb begin
        n1_side.par = 1'b0;
        n1_side.ovf = |w1_f;
        n1_side.p1  = w_p1;
        n1_side.d1  = w_d1;
        n1_side.p2  = w_p2;
        n1_side.d2  = w_d2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld  <= i_valid;
            r1_cm   <= n1_cm;
            r1_pd   <= n1_pd;
            r1_side <= n1_side;
        end
    end

    for (genvar g = 0; g < 3; g++) begin : g_s2
        localparam int J = (g + 1) % 3;
        localparam int M = (g + 2) % 3;
        logic [32:0] w_c;
        assign w_c     = lca_pkg::sat32(66'(r1_cm[2*g]) - 66'(r1_cm[2*g+1]));
        assign n2_c[g] = w_c[31:0];
        assign w2_f[g] = w_c[32];
        assign n2_um[2*g]   = lca_pkg::fmul(r1_pd[J], $signed(r1_side.d2[M]), FRAC_BITS);
        assign n2_um[2*g+1] = lca_pkg::fmul(r1_pd[M], $signed(r1_side.d2[J]), FRAC_BITS);
        assign n2_vm[2*g]   = lca_pkg::fmul(r1_pd[J], $signed(r1_side.d1[M]), FRAC_BITS);
        assign n2_vm[2*g+1] = lca_pkg::fmul(r1_pd[M], $signed(r1_side.d1[J]), FRAC_BITS);
    end

    always_comb begin
        n2_side     = r1_side;
        n2_side.ovf = r1_side.ovf | (|w2_f);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (i_en) begin
            r2_vld  <= r1_vld;
            r2_c    <= n2_c;
            r2_um   <= n2_um;
            r2_vm   <= n2_vm;
            r2_side <= n2_side;
        end
    end

    for (genvar g = 0; g < 3; g++) begin : g_s3
        logic [32:0] w_u, w_v;
        assign w_u       = lca_pkg::sat32(66'(r2_um[2*g]) - 66'(r2_um[2*g+1]));
        assign w_v       = lca_pkg::sat32(66'(r2_vm[2*g]) - 66'(r2_vm[2*g+1]));
        assign n3_u[g]   = w_u[31:0];
        assign n3_v[g]   = w_v[31:0];
        assign w3_f[g]   = w_u[32];
        assign w3_f[g+3] = w_v[32];
        assign n3_cc[g]  = lca_pkg::fmul(r2_c[g], r2_c[g], FRAC_BITS);
    end

    always_comb begin
        n3_side     = r2_side;
        n3_side.ovf = r2_side.ovf | (|w3_f);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (i_en) begin
            r3_vld  <= r2_vld;
            r3_u    <= n3_u;
            r3_v    <= n3_v;
            r3_c    <= r2_c;
            r3_cc   <= n3_cc;
            r3_side <= n3_side;
        end
    end

    for (genvar g = 0; g < 3; g++) begin : g_s4
        assign n4_uc[g] = lca_pkg::fmul(r3_u[g], r3_c[g], FRAC_BITS);
        assign n4_vc[g] = lca_pkg::fmul(r3_v[g], r3_c[g], FRAC_BITS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (i_en) begin
            r4_vld  <= r3_vld;
            r4_uc   <= n4_uc;
            r4_vc   <= n4_vc;
            r4_k    <= 64'(r3_cc[0] + r3_cc[1] + r3_cc[2]);
            r4_side <= r3_side;
        end
    end

    always_comb begin
        n5_side     = r4_side;
        n5_side.par = (r4_k == 64'd0) || (r4_k < {32'd0, i_eps});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else if (i_en) begin
            r5_vld  <= r4_vld;
            r5_n1   <= r4_uc[0] + r4_uc[1] + r4_uc[2];
            r5_n2   <= r4_vc[0] + r4_vc[1] + r4_vc[2];
            r5_k    <= r4_k;
            r5_side <= n5_side;
        end
    end

    // |n| * 2^F fits 64 bits for every F in range
    always_comb begin
        n6_data.side = r5_side;
        n6_data.k    = r5_k;
        n6_data.neg1 = r5_n1[63];
        n6_data.neg2 = r5_n2[63];
        n6_data.dvd1 = (r5_n1[63] ? 64'(-r5_n1) : 64'(r5_n1)) << FRAC_BITS;
        n6_data.dvd2 = (r5_n2[63] ? 64'(-r5_n2) : 64'(r5_n2)) << FRAC_BITS;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
        end else if (i_en) begin
            r6_vld  <= r5_vld;
            r6_data <= n6_data;
        end
    end

    assign o_valid = r6_vld;
    assign o_data  = r6_data;

endmodule

[sv/lca_div.sv]
`timescale 1ns / 1ps
// Dual pipelined restoring divider, one quotient bit per stage, with signed saturation.
// Depends on lca_pkg.
module lca_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  lca_pkg::t_div_in  i_data,
    output logic              o_valid,
    output lca_pkg::t_div_out o_data
);

    localparam int QB = lca_pkg::QBITS;

    logic                r_vld  [QB+1];
    logic [63:0]         r_rem1 [QB+1];
    logic [63:0]         r_rem2 [QB+1];
    logic [QB-1:0]       r_q1   [QB+1];
    logic [QB-1:0]       r_q2   [QB+1];
    logic [63:0]         r_dvd1 [QB+1];
    logic [63:0]         r_dvd2 [QB+1];
    logic [63:0]         r_k    [QB+1];
    logic                r_pre1 [QB+1];
    logic                r_pre2 [QB+1];
    logic                r_neg1 [QB+1];
    logic                r_neg2 [QB+1];
    lca_pkg::t_side      r_side [QB+1];

    logic                r_out_vld;
    lca_pkg::t_div_out   r_out;
    lca_pkg::t_div_out   n_out;
    logic                w_sat1, w_sat2;

    // Quotient of 2^QB or more saturates either sign: flag it up front.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0]  <= i_valid;
            r_rem1[0] <= i_data.dvd1 >> QB;
            r_rem2[0] <= i_data.dvd2 >> QB;
            r_pre1[0] <= (i_data.dvd1 >> QB) >= i_data.k;
            r_pre2[0] <= (i_data.dvd2 >> QB) >= i_data.k;
            r_q1[0]   <= '0;
            r_q2[0]   <= '0;
            r_dvd1[0] <= i_data.dvd1;
            r_dvd2[0] <= i_data.dvd2;
            r_k[0]    <= i_data.k;
            r_neg1[0] <= i_data.neg1;
            r_neg2[0] <= i_data.neg2;
            r_side[0] <= i_data.side;
        end
    end

    for (genvar s = 1; s <= QB; s++) begin : g_stage
        localparam int B = QB - s;
        logic [63:0]   w_sh1, w_sh2;
        logic          w_ge1, w_ge2;
        logic [QB-1:0] n_q1, n_q2;

        assign w_sh1 = {r_rem1[s-1][62:0], r_dvd1[s-1][B]};
        assign w_sh2 = {r_rem2[s-1][62:0], r_dvd2[s-1][B]};
        assign w_ge1 = w_sh1 >= r_k[s-1];
        assign w_ge2 = w_sh2 >= r_k[s-1];

        always_comb begin
            n_q1    = r_q1[s-1];
            n_q2    = r_q2[s-1];
            n_q1[B] = w_ge1;
            n_q2[B] = w_ge2;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s]  <= r_vld[s-1];
                r_rem1[s] <= w_ge1 ? w_sh1 - r_k[s-1] : w_sh1;
                r_rem2[s] <= w_ge2 ? w_sh2 - r_k[s-1] : w_sh2;
                r_q1[s]   <= n_q1;
                r_q2[s]   <= n_q2;
                r_pre1[s] <= r_pre1[s-1];
                r_pre2[s] <= r_pre2[s-1];
                r_dvd1[s] <= r_dvd1[s-1];
                r_dvd2[s] <= r_dvd2[s-1];
                r_k[s]    <= r_k[s-1];
                r_neg1[s] <= r_neg1[s-1];
                r_neg2[s] <= r_neg2[s-1];
                r_side[s] <= r_side[s-1];
            end
        end
    end

    // positive limit 2^31-1, negative limit 2^31
    assign w_sat1 = r_pre1[QB] | r_q1[QB][QB-1] |
                    (r_neg1[QB] ? (r_q1[QB][QB-2] & (|r_q1[QB][QB-3:0])) : r_q1[QB][QB-2]);
    assign w_sat2 = r_pre2[QB] | r_q2[QB][QB-1] |
                    (r_neg2[QB] ? (r_q2[QB][QB-2] & (|r_q2[QB][QB-3:0])) : r_q2[QB][QB-2]);

    always_comb begin
        n_out.side     = r_side[QB];
        n_out.side.ovf = r_side[QB].ovf | w_sat1 | w_sat2;
        if (w_sat1) begin
            n_out.t1 = r_neg1[QB] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            n_out.t1 = r_neg1[QB] ? -$signed(r_q1[QB][31:0]) : $signed(r_q1[QB][31:0]);
        end
        if (w_sat2) begin
            n_out.t2 = r_neg2[QB] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            n_out.t2 = r_neg2[QB] ? -$signed(r_q2[QB][31:0]) : $signed(r_q2[QB][31:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_en) begin
            r_out_vld <= r_vld[QB];
            r_out     <= n_out;
        end
    end

    assign o_valid = r_out_vld;
    assign o_data  = r_out;

endmodule

[sv/lca_back.sv]
`timescale 1ns / 1ps
// Back pipeline: closest points, their difference, squared distance and meet test.
// Depends on lca_pkg.
module lca_back #(
    parameter int FRAC_BITS = lca_pkg::FRAC_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  lca_pkg::t_div_out i_data,
    input  logic [31:0]       i_eps,
    output logic              o_valid,
    output lca_pkg::t_root_in o_data
);

    lca_pkg::t_tail     n1_tail;
    logic signed [63:0] n1_m1 [3];
    logic signed [63:0] n1_m2 [3];
    logic signed [63:0] r1_m1 [3];
    logic signed [63:0] r1_m2 [3];
    lca_pkg::t_vec3     r1_p1, r1_p2;
    lca_pkg::t_tail     r1_tail;
    logic               r1_vld;

    logic [5:0]         w2_f;
    logic signed [31:0] n2_q1 [3];
    logic signed [31:0] n2_q2 [3];
    lca_pkg::t_tail     n2_tail;
    logic signed [31:0] r2_q1 [3];
    logic signed [31:0] r2_q2 [3];
    lca_pkg::t_tail     r2_tail;
    logic               r2_vld;

    logic [2:0]         w3_f;
    logic signed [31:0] n3_w [3];
    lca_pkg::t_tail     n3_tail;
    logic signed [31:0] r3_w [3];
    lca_pkg::t_tail     r3_tail;
    logic               r3_vld;

    logic signed [63:0] n4_ww [3];
    logic signed [63:0] r4_ww [3];
    lca_pkg::t_tail     r4_tail;
    logic               r4_vld;

    logic [63:0]        r5_s;
    lca_pkg::t_tail     r5_tail;
    logic               r5_vld;

    lca_pkg::t_root_in  n6_data;
    lca_pkg::t_root_in  r6_data;
    logic               r6_vld;

    for (genvar g = 0; g < 3; g++) begin : g_s1
        assign n1_m1[g] = lca_pkg::fmul(i_data.t1, $signed(i_data.side.d1[g]), FRAC_BITS);
        assign n1_m2[g] = lca_pkg::fmul(i_data.t2, $signed(i_data.side.d2[g]), FRAC_BITS);
    end

    always_comb begin
        n1_tail.par  = i_data.side.par;
        n1_tail.ovf  = i_data.side.ovf;
        n1_tail.meet = 1'b0;
        n1_tail.t1   = i_data.t1;
        n1_tail.t2   = i_data.t2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld  <= i_valid;
            r1_m1   <= n1_m1;
            r1_m2   <= n1_m2;
            r1_p1   <= i_data.side.p1;
            r1_p2   <= i_data.side.p2;
            r1_tail <= n1_tail;
        end
    end

    for (genvar g = 0; g < 3; g++) begin : g_s2
        logic [32:0] w_q1, w_q2;
        assign w_q1      = lca_pkg::sat32(66'($signed(r1_p1[g])) + 66'(r1_m1[g]));
        assign w_q2      = lca_pkg::sat32(66'($signed(r1_p2[g])) + 66'(r1_m2[g]));
        assign n2_q1[g]  = w_q1[31:0];
        assign n2_q2[g]  = w_q2[31:0];
        assign w2_f[g]   = w_q1[32];
        assign w2_f[g+3] = w_q2[32];
    end

    always_comb begin
        n2_tail     = r1_tail;
        n2_tail.ovf = r1_tail.ovf | (|w2_f);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (i_en) begin
            r2_vld  <= r1_vld;
            r2_q1   <= n2_q1;
            r2_q2   <= n2_q2;
            r2_tail <= n2_tail;
        end
    end

    for (genvar g = 0; g < 3; g++) begin : g_s3
        logic [32:0] w_w;
        assign w_w     = lca_pkg::sat32(66'(r2_q1[g]) - 66'(r2_q2[g]));
        assign n3_w[g] = w_w[31:0];
        assign w3_f[g] = w_w[32];
    end

    always_comb begin
        n3_tail     = r2_tail;
        n3_tail.ovf = r2_tail.ovf | (|w3_f);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (i_en) begin
            r3_vld  <= r2_vld;
            r3_w    <= n3_w;
            r3_tail <= n3_tail;
        end
    end

    for (genvar g = 0; g < 3; g++) begin : g_s4
        assign n4_ww[g] = lca_pkg::fmul(r3_w[g], r3_w[g], FRAC_BITS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (i_en) begin
            r4_vld  <= r3_vld;
            r4_ww   <= n4_ww;
            r4_tail <= r3_tail;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else if (i_en) begin
            r5_vld  <= r4_vld;
            r5_s    <= 64'(r4_ww[0] + r4_ww[1] + r4_ww[2]);
            r5_tail <= r4_tail;
        end
    end

    always_comb begin
        n6_data.tail      = r5_tail;
        n6_data.tail.meet = r5_s < {32'd0, i_eps};
        n6_data.x         = r5_s << FRAC_BITS;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
        end else if (i_en) begin
            r6_vld  <= r5_vld;
            r6_data <= n6_data;
        end
    end

    assign o_valid = r6_vld;
    assign o_data  = r6_data;

endmodule

[sv/lca_sqrt.sv]
`timescale 1ns / 1ps
// Pipelined integer square root of a 64-bit value, one root bit per stage.
// Depends on lca_pkg.
module lca_sqrt (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  lca_pkg::t_root_in  i_data,
    output logic               o_valid,
    output lca_pkg::t_root_out o_data
);

    localparam int RB = lca_pkg::ROOT_BITS;

    logic                 r_vld  [RB+1];
    logic [RB+1:0]        r_rem  [RB+1];
    logic [RB-1:0]        r_root [RB+1];
    logic [2*RB-1:0]      r_x    [RB+1];
    lca_pkg::t_tail       r_tail [RB+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0]  <= i_valid;
            r_rem[0]  <= '0;
            r_root[0] <= '0;
            r_x[0]    <= i_data.x;
            r_tail[0] <= i_data.tail;
        end
    end

    for (genvar s = 1; s <= RB; s++) begin : g_stage
        localparam int I = RB - s;
        logic [RB+3:0] w_sh, w_test;
        logic          w_ge;

        assign w_sh   = {r_rem[s-1], r_x[s-1][2*I+1:2*I]};
        assign w_test = {2'b00, r_root[s-1], 2'b01};
        assign w_ge   = w_sh >= w_test;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s]  <= r_vld[s-1];
                r_rem[s]  <= w_ge ? (RB+2)'(w_sh - w_test) : w_sh[RB+1:0];
                r_root[s] <= {r_root[s-1][RB-2:0], w_ge};
                r_x[s]    <= r_x[s-1];
                r_tail[s] <= r_tail[s-1];
            end
        end
    end

    assign o_valid     = r_vld[RB];
    assign o_data.tail = r_tail[RB];
    assign o_data.root = r_root[RB];

endmodule

[sv/line_closest_approach_3d.sv]
`timescale 1ns / 1ps
// Top level of the 3D line closest-approach block: epsilon register, pipeline, output beat.
// Depends on lca_pkg, lca_geom, lca_div, lca_back, lca_sqrt.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) takes one line pair per beat:
//   origin and direction of each line, signed fixed point with FRAC_BITS fraction bits.
//   Output channel (o_out_valid / i_out_stall / o_out_data) returns one result per beat:
//   not_parallel, both line parameters, distance, meet flag and overflow flag. Users write
//   epsilon (i_cfg_we / i_cfg_wdata) only while the block is empty, unchecked by the block.
//
// Throughput: one beat per cycle while the output is unstalled. Every stage is a register;
//   the divider retires one quotient bit per stage and the root one result bit per stage,
//   so nothing iterates. A beat passes 6 front stages, 35 divider stages, 6 back stages,
//   33 root stages and the output register on its way to o_out_valid.
// Stall: the whole pipeline holds while the output beat waits under i_out_stall;
//   o_in_stall then goes high in the same cycle, and no beat is dropped or repeated.
// Reset: synchronous, active low; clears every stage valid and sets epsilon to 1.
module line_closest_approach_3d #(
    parameter int FRAC_BITS = lca_pkg::FRAC_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  lca_pkg::t_lca_in  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output lca_pkg::t_lca_out o_out_data,
    input  logic              i_cfg_we,
    input  logic [31:0]       i_cfg_wdata
);

    // stages an item can occupy, used by the occupancy check below
    localparam int DEPTH = 81;

    logic [31:0]        r_eps;
    logic               w_en;

    logic               w_geo_vld, w_div_vld, w_back_vld, w_root_vld;
    lca_pkg::t_div_in   w_geo;
    lca_pkg::t_div_out  w_div;
    lca_pkg::t_root_in  w_back;
    lca_pkg::t_root_out w_root;

    lca_pkg::t_lca_out  n_out;
    lca_pkg::t_lca_out  r_out;
    logic               r_out_vld;

    logic [6:0]         r_cnt;

    // Pipeline moves whenever the output slot is free or being taken.
    assign w_en       = !(r_out_vld && i_out_stall);
    assign o_in_stall = !w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps <= 32'd1;
        end else if (i_cfg_we) begin
            r_eps <= i_cfg_wdata;
        end
    end

    lca_geom #(.FRAC_BITS(FRAC_BITS)) u_geom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_in_valid),
        .i_data  (i_in_data),
        .i_eps   (r_eps),
        .o_valid (w_geo_vld),
        .o_data  (w_geo)
    );

    lca_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_geo_vld),
        .i_data  (w_geo),
        .o_valid (w_div_vld),
        .o_data  (w_div)
    );

    lca_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_div_vld),
        .i_data  (w_div),
        .i_eps   (r_eps),
        .o_valid (w_back_vld),
        .o_data  (w_back)
    );

    lca_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_back_vld),
        .i_data  (w_back),
        .o_valid (w_root_vld),
        .o_data  (w_root)
    );

    // Parallel pairs report all zeros, overflow included.
    always_comb begin
        if (w_root.tail.par) begin
            n_out = '0;
        end else begin
            n_out.not_parallel  = 1'b1;
            n_out.first_param   = w_root.tail.t1;
            n_out.second_param  = w_root.tail.t2;
            n_out.line_distance = w_root.root;
            n_out.lines_meet    = w_root.tail.meet;
            n_out.overflow      = w_root.tail.ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= w_root_vld;
            r_out     <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // items accepted and not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= r_cnt + 7'(i_in_valid && !o_in_stall) - 7'(o_out_valid && !i_out_stall);
        end
    end

    a_occupancy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 7'(DEPTH))
        else $error("more beats in flight than pipeline stages");

    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_cnt != 7'd0)
        else $error("output beat without an accepted input");

    a_parallel_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.not_parallel |->
            o_out_data.first_param == '0 && o_out_data.second_param == '0 &&
            o_out_data.line_distance == '0 && !o_out_data.lines_meet &&
            !o_out_data.overflow)
        else $error("parallel result carries nonzero fields");

endmodule
